>>> design/gamma_rgb_to_xyz_converter_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the gamma RGB to XYZ converter core
// Clocked property shorthands with synchronous active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef GAMMA_RGB_TO_XYZ_CONVERTER_CORE_ASSERT_SVH
`define GAMMA_RGB_TO_XYZ_CONVERTER_CORE_ASSERT_SVH

// Same-cycle implication.
`define GXYZ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define GXYZ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/gxyz_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gxyz_pkg
// Widths, codes, pipeline control type and matrix coefficients shared by
// the converter core and its matrix datapath.
// ----------------------------------------------------------------------------
package gxyz_pkg;

    localparam int SAMPLE_BITS      = 16;
    localparam int ENCODE_OVERSAMPLE = 8;
    localparam int LINEAR_FRAC_BITS = 24;
    localparam int COEF_FRAC_BITS   = 16;

    localparam int DEC_DEPTH  = 2 ** SAMPLE_BITS;
    localparam int ENC_DEPTH  = DEC_DEPTH * ENCODE_OVERSAMPLE;
    localparam int DEC_IDX_W  = SAMPLE_BITS;
    localparam int ENC_IDX_W  = $clog2(ENC_DEPTH);
    localparam int TIDX_W     = 19;
    localparam int TVAL_W     = 25;
    localparam int CODE_W     = 16;
    localparam int LIN_W      = LINEAR_FRAC_BITS + 1;
    localparam int COEF_W     = COEF_FRAC_BITS + 1;
    localparam int PROD_W     = LIN_W + COEF_W;
    localparam int SUM_W      = PROD_W + 2;
    localparam int SUM_FRAC   = LINEAR_FRAC_BITS + COEF_FRAC_BITS;
    localparam int SAT_W      = SUM_FRAC + 1;
    localparam int SCALED_W   = SAT_W + ENC_IDX_W;
    localparam int NCH        = 3;

    localparam logic [SUM_W-1:0]  SUM_ONE  = SUM_W'(1) << SUM_FRAC;
    localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1) << COEF_FRAC_BITS;

    typedef enum logic [1:0] {
        ACT_CONVERT = 2'd0,
        ACT_DEC_WR  = 2'd1,
        ACT_ENC_WR  = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        MSEL_IDENTITY = 2'd0,
        MSEL_DC28     = 2'd1,
        MSEL_FILM     = 2'd2
    } t_msel;

    typedef logic [NCH-1:0][LIN_W-1:0]     t_lin_vec;
    typedef logic [NCH-1:0][ENC_IDX_W-1:0] t_idx_vec;
    typedef logic [NCH-1:0][CODE_W-1:0]    t_code_vec;

    // Control that rides along with each item through the pipeline
    typedef struct packed {
        logic                 pix;
        logic                 encw;
        logic [ENC_IDX_W-1:0] widx;
        logic [CODE_W-1:0]    wval;
    } t_ctl;

    typedef logic [COEF_W-1:0] t_mat [NCH][NCH];

    localparam t_mat MAT_DC28 = '{
        '{COEF_W'(29175), COEF_W'(18162), COEF_W'(11291)},
        '{COEF_W'(13729), COEF_W'(47290), COEF_W'(4516)},
        '{COEF_W'(0),     COEF_W'(3084),  COEF_W'(59464)}
    };

    localparam t_mat MAT_FILM = '{
        '{COEF_W'(30409), COEF_W'(17642), COEF_W'(10551)},
        '{COEF_W'(14320), COEF_W'(45941), COEF_W'(5276)},
        '{COEF_W'(0),     COEF_W'(2995),  COEF_W'(59553)}
    };

    // Q1.COEF_FRAC_BITS coefficient; unused select code falls back to identity
    function automatic logic [COEF_W-1:0] coef_q(input logic [1:0] msel,
                                                 input int unsigned row,
                                                 input int unsigned col);
        logic [COEF_W-1:0] c;
        unique case (msel)
            MSEL_DC28: c = MAT_DC28[row][col];
            MSEL_FILM: c = MAT_FILM[row][col];
            default:   c = (row == col) ? COEF_ONE : '0;
        endcase
        return c;
    endfunction

endpackage

>>> design/gxyz_matrix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gxyz_matrix
// Three-stage matrix datapath: nine products, row sums with saturation at
// 1.0, then scaling by (encode depth - 1) into encode table addresses.
// ----------------------------------------------------------------------------
module gxyz_matrix
    import gxyz_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic [1:0] i_msel,
    input  t_ctl       i_ctl,
    input  t_lin_vec   i_lin,
    output t_ctl       o_ctl,
    output t_idx_vec   o_idx
);

    t_ctl              r_b_ctl, r_c_ctl, r_d_ctl;
    logic [PROD_W-1:0] r_prod [NCH][NCH];
    logic [SAT_W-1:0]  r_sat  [NCH];
    t_idx_vec          r_idx;

    logic [SUM_W-1:0]    w_sum    [NCH];
    logic [SCALED_W-1:0] w_scaled [NCH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_ctl.pix  <= 1'b0;
            r_b_ctl.encw <= 1'b0;
            r_c_ctl.pix  <= 1'b0;
            r_c_ctl.encw <= 1'b0;
            r_d_ctl.pix  <= 1'b0;
            r_d_ctl.encw <= 1'b0;
        end else if (i_en) begin
            r_b_ctl <= i_ctl;
            r_c_ctl <= r_b_ctl;
            r_d_ctl <= r_c_ctl;
        end
    end

    // Stage B: products of linear samples and coefficients
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < NCH; r++) begin
                for (int c = 0; c < NCH; c++) begin
                    r_prod[r][c] <= PROD_W'(i_lin[c]) * PROD_W'(coef_q(i_msel, r, c));
                end
            end
        end
    end

    // Stage C: row sum, clamp to 1.0
    always_comb begin
        for (int r = 0; r < NCH; r++) begin
            w_sum[r] = SUM_W'(r_prod[r][0]) + SUM_W'(r_prod[r][1]) + SUM_W'(r_prod[r][2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < NCH; r++) begin
                r_sat[r] <= (w_sum[r] > SUM_ONE) ? SUM_ONE[SAT_W-1:0] : w_sum[r][SAT_W-1:0];
            end
        end
    end

    // Stage D: floor(s * (D - 1) / 2^SUM_FRAC), D a power of two
    always_comb begin
        for (int r = 0; r < NCH; r++) begin
            w_scaled[r] = {r_sat[r], {ENC_IDX_W{1'b0}}} - {{ENC_IDX_W{1'b0}}, r_sat[r]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < NCH; r++) begin
                r_idx[r] <= w_scaled[r][SUM_FRAC +: ENC_IDX_W];
            end
        end
    end

    assign o_ctl = r_d_ctl;
    assign o_idx = r_idx;

endmodule

>>> design/gamma_rgb_to_xyz_converter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gamma_rgb_to_xyz_converter_core
// Gamma-coded RGB to gamma-coded XYZ pixel pipeline with loadable decode
// and encode tables and a selectable fixed color matrix.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | i_in_valid / o_in_ready, action, samples, | into core
//          | table_index, table_value                  |
//  out     | o_out_valid / i_out_ready, x/y/z codes    | out of core
//  cfg     | i_cfg_we / i_cfg_wdata (matrix select)    | into core
//
//  One item per clock while the skid register is empty. A converted pixel
//  passes five stages before it is valid at the output: decode table read,
//  multiply, sum/clamp, scale, encode table read.
//  Table writes take no output slot; decode writes land in the first stage,
//  encode writes in the last stage, so they stay in order with pixels.
//  A one-entry skid register holds a stalled result; o_in_ready drops while
//  it is full. Synchronous active-low reset clears only control state.
// ----------------------------------------------------------------------------
`include "gamma_rgb_to_xyz_converter_core_assert.svh"

module gamma_rgb_to_xyz_converter_core
    import gxyz_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_action,
    input  logic [15:0]       i_red,
    input  logic [15:0]       i_green,
    input  logic [15:0]       i_blue,
    input  logic [TIDX_W-1:0] i_table_index,
    input  logic [TVAL_W-1:0] i_table_value,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [CODE_W-1:0] o_x_code,
    output logic [CODE_W-1:0] o_y_code,
    output logic [CODE_W-1:0] o_z_code
);

    logic [1:0] r_msel;
    t_ctl       r_a_ctl;
    t_lin_vec   r_lin;
    logic       r_e_pix;
    t_code_vec  r_code;
    logic       r_sv;
    t_code_vec  r_skid;

    logic                              w_en;
    logic                              w_acc;
    logic                              w_dec_wr;
    logic [NCH-1:0][DEC_IDX_W-1:0]     w_sample;
    t_ctl                              w_a_ctl;
    t_ctl                              w_d_ctl;
    t_idx_vec                          w_d_idx;
    t_code_vec                         w_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_msel <= MSEL_DC28;
        end else if (i_cfg_we) begin
            r_msel <= i_cfg_wdata;
        end
    end

    // Whole pipeline advances unless the skid register is holding a result
    assign w_en       = !r_sv;
    assign o_in_ready = w_en;
    assign w_acc      = i_in_valid && w_en;
    assign w_dec_wr   = w_acc && (i_action == ACT_DEC_WR) &&
                        (i_table_index[TIDX_W-1:DEC_IDX_W] == '0);

    assign w_sample[0] = i_red[DEC_IDX_W-1:0];
    assign w_sample[1] = i_green[DEC_IDX_W-1:0];
    assign w_sample[2] = i_blue[DEC_IDX_W-1:0];

    always_comb begin
        w_a_ctl.pix  = w_acc && (i_action == ACT_CONVERT);
        w_a_ctl.encw = w_acc && (i_action == ACT_ENC_WR);
        w_a_ctl.widx = i_table_index[ENC_IDX_W-1:0];
        w_a_ctl.wval = i_table_value[CODE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl.pix  <= 1'b0;
            r_a_ctl.encw <= 1'b0;
        end else if (w_en) begin
            r_a_ctl <= w_a_ctl;
        end
    end

    // Stage A: one decode table copy per channel, written together
    for (genvar k = 0; k < NCH; k++) begin : g_dec
        logic [LIN_W-1:0] r_dec_mem [DEC_DEPTH];

        always_ff @(posedge i_clk) begin
            if (w_dec_wr) begin
                r_dec_mem[i_table_index[DEC_IDX_W-1:0]] <= i_table_value[LIN_W-1:0];
            end
            if (w_en) begin
                r_lin[k] <= r_dec_mem[w_sample[k]];
            end
        end
    end

    gxyz_matrix u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_msel  (r_msel),
        .i_ctl   (r_a_ctl),
        .i_lin   (r_lin),
        .o_ctl   (w_d_ctl),
        .o_idx   (w_d_idx)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_pix <= 1'b0;
        end else if (w_en) begin
            r_e_pix <= w_d_ctl.pix;
        end
    end

    // Stage E: one encode table copy per channel; writes keep pipeline order
    for (genvar k = 0; k < NCH; k++) begin : g_enc
        logic [CODE_W-1:0] r_enc_mem [ENC_DEPTH];

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                if (w_d_ctl.encw) begin
                    r_enc_mem[w_d_ctl.widx] <= w_d_ctl.wval;
                end else begin
                    r_code[k] <= r_enc_mem[w_d_idx[k]];
                end
            end
        end
    end

    // Park a result that the sink did not take while the pipeline moved on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (i_out_ready) begin
                r_sv <= 1'b0;
            end
        end else if (r_e_pix && !i_out_ready) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_sv) begin
            r_skid <= r_code;
        end
    end

    assign o_out_valid = r_sv || r_e_pix;
    assign w_out       = r_sv ? r_skid : r_code;
    assign o_x_code    = w_out[0];
    assign o_y_code    = w_out[1];
    assign o_z_code    = w_out[2];

    `GXYZ_ASSERT_NOW(a_ctl_one_kind, i_clk, i_rst_n, w_d_ctl.pix, !w_d_ctl.encw,
        "pixel and encode write share a pipeline slot")
    `GXYZ_ASSERT_NEXT(a_stall_holds_result, i_clk, i_rst_n, !w_en && r_e_pix, r_e_pix,
        "result lost from last stage during stall")
    `GXYZ_ASSERT_NEXT(a_skid_catches, i_clk, i_rst_n, w_en && r_e_pix && !i_out_ready,
        r_sv, "untaken result not parked in skid register")

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the gamma RGB to XYZ converter core. Loads the
// decode and encode tables through the input channel, converts pixels that
// only touch loaded entries, and compares every output transfer with codes
// computed in the bench from its own copy of the tables and the matrix.
// ----------------------------------------------------------------------------
import gxyz_pkg::*;

class xyz_code_scoreboard;

    typedef struct {
        logic [CODE_W-1:0] x;
        logic [CODE_W-1:0] y;
        logic [CODE_W-1:0] z;
    } xyz_codes_t;

    localparam longint unsigned SAT_ONE = 64'd1 << SUM_FRAC;
    localparam longint unsigned DEC_SCALE = 64'd10000000000;

    logic [LIN_W-1:0]  dec_tab [DEC_DEPTH];
    logic [CODE_W-1:0] enc_tab [ENC_DEPTH];
    bit                dec_seen [DEC_DEPTH];
    bit                enc_seen [ENC_DEPTH];
    int                dec_list [$];
    longint unsigned   coef [3][3];
    xyz_codes_t        pending_codes [$];
    int                errors;
    int                checked;

    function new();
        errors  = 0;
        checked = 0;
        set_matrix(MSEL_DC28);
    endfunction

    // Round the decimal coefficients to Q1.COEF_FRAC_BITS
    function void set_matrix(logic [1:0] sel);
        longint unsigned dc [9];
        case (sel)
            MSEL_DC28: dc = '{64'd4451698156, 64'd2771344092, 64'd1722826698,
                              64'd2094916779, 64'd7215952542, 64'd689130679,
                              64'd0, 64'd470605601, 64'd9073553944};
            MSEL_FILM: dc = '{64'd4640000000, 64'd2692000000, 64'd1610000000,
                              64'd2185000000, 64'd7010000000, 64'd805000000,
                              64'd0, 64'd457000000, 64'd9087000000};
            default:   dc = '{DEC_SCALE, 64'd0, 64'd0,
                              64'd0, DEC_SCALE, 64'd0,
                              64'd0, 64'd0, DEC_SCALE};
        endcase
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                coef[r][c] = (dc[r*3+c] * (64'd1 << COEF_FRAC_BITS) + DEC_SCALE / 2)
                             / DEC_SCALE;
            end
        end
    endfunction

    function int unsigned encode_addr(logic [LIN_W-1:0] l0, logic [LIN_W-1:0] l1,
                                      logic [LIN_W-1:0] l2, int row);
        longint unsigned s;
        s = 64'(l0) * coef[row][0] + 64'(l1) * coef[row][1] + 64'(l2) * coef[row][2];
        if (s > SAT_ONE) begin
            s = SAT_ONE;
        end
        return int'((s * 64'(ENC_DEPTH - 1)) >> SUM_FRAC);
    endfunction

    function void note_transfer(logic [1:0] act, logic [15:0] r, logic [15:0] g,
                                logic [15:0] b, logic [TIDX_W-1:0] tidx,
                                logic [TVAL_W-1:0] tval);
        xyz_codes_t c;
        logic [LIN_W-1:0] l0, l1, l2;
        case (act)
            ACT_DEC_WR: begin
                if (tidx < DEC_DEPTH) begin
                    dec_tab[tidx[DEC_IDX_W-1:0]] = tval[LIN_W-1:0];
                    if (!dec_seen[tidx[DEC_IDX_W-1:0]]) begin
                        dec_seen[tidx[DEC_IDX_W-1:0]] = 1'b1;
                        dec_list.push_back(int'(tidx));
                    end
                end
            end
            ACT_ENC_WR: begin
                if (tidx < ENC_DEPTH) begin
                    enc_tab[tidx] = tval[CODE_W-1:0];
                    enc_seen[tidx] = 1'b1;
                end
            end
            ACT_CONVERT: begin
                l0 = dec_tab[r];
                l1 = dec_tab[g];
                l2 = dec_tab[b];
                c.x = enc_tab[encode_addr(l0, l1, l2, 0)];
                c.y = enc_tab[encode_addr(l0, l1, l2, 1)];
                c.z = enc_tab[encode_addr(l0, l1, l2, 2)];
                pending_codes.push_back(c);
            end
            default: ;
        endcase
    endfunction

    function void compare_field(string name, logic [CODE_W-1:0] want,
                                logic [CODE_W-1:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
        end
    endfunction

    function void check_codes(logic [CODE_W-1:0] x, logic [CODE_W-1:0] y,
                              logic [CODE_W-1:0] z);
        xyz_codes_t e;
        if (pending_codes.size() == 0) begin
            errors++;
            $display("%0t: result with nothing pending, expected none actual %h %h %h",
                     $time, x, y, z);
            return;
        end
        e = pending_codes.pop_front();
        checked++;
        compare_field("x_code", e.x, x);
        compare_field("y_code", e.y, y);
        compare_field("z_code", e.z, z);
    endfunction

endclass

module testbench;

    localparam logic [1:0] ACT_UNUSED  = 2'd3;
    localparam logic [1:0] MSEL_UNUSED = 2'd3;
    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_GAP      = 20;
    localparam int PHASE_ITEMS  = 165;
    localparam int N_PHASES     = 8;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [1:0]        i_cfg_wdata;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [1:0]        i_action;
    logic [15:0]       i_red;
    logic [15:0]       i_green;
    logic [15:0]       i_blue;
    logic [TIDX_W-1:0] i_table_index;
    logic [TVAL_W-1:0] i_table_value;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [CODE_W-1:0] o_x_code;
    logic [CODE_W-1:0] o_y_code;
    logic [CODE_W-1:0] o_z_code;

    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int sent_items      = 0;
    int cycle_count     = 0;

    xyz_code_scoreboard sb = new();

    gamma_rgb_to_xyz_converter_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_action      (i_action),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .i_table_index (i_table_index),
        .i_table_value (i_table_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_x_code      (o_x_code),
        .o_y_code      (o_y_code),
        .o_z_code      (o_z_code)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Output side: check each transfer, then pick the next ready level
    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                sb.check_codes(o_x_code, o_y_code, o_z_code);
            end
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [15:0] rnd16();
        return 16'($urandom);
    endfunction

    function automatic logic [TIDX_W-1:0] rnd_idx();
        return TIDX_W'($urandom);
    endfunction

    function automatic logic [TVAL_W-1:0] rnd_val();
        return TVAL_W'($urandom);
    endfunction

    // Called at the edge of the previous transfer; returns at the edge of this one
    task automatic send_item(input logic [1:0] act, input logic [15:0] r,
                             input logic [15:0] g, input logic [15:0] b,
                             input logic [TIDX_W-1:0] tidx,
                             input logic [TVAL_W-1:0] tval);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_action      <= act;
        i_red         <= r;
        i_green       <= g;
        i_blue        <= b;
        i_table_index <= tidx;
        i_table_value <= tval;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_transfer(act, r, g, b, tidx, tval);
        sent_items++;
    endtask

    // Load any encode entry the pixel will hit before sending the pixel
    task automatic send_pixel(input logic [15:0] r, input logic [15:0] g,
                              input logic [15:0] b);
        int unsigned addr;
        for (int row = 0; row < 3; row++) begin
            addr = sb.encode_addr(sb.dec_tab[r], sb.dec_tab[g], sb.dec_tab[b], row);
            if (!sb.enc_seen[addr]) begin
                send_item(ACT_ENC_WR, rnd16(), rnd16(), rnd16(), TIDX_W'(addr), rnd_val());
            end
        end
        send_item(ACT_CONVERT, r, g, b, rnd_idx(), rnd_val());
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (sb.pending_codes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_matrix(input logic [1:0] sel);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= sel;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_matrix(sel);
    endtask

    function automatic logic [TVAL_W-1:0] rand_linear();
        case ($urandom_range(5))
            0:       return '0;
            1:       return TVAL_W'(1) << LINEAR_FRAC_BITS;
            2:       return '1;
            3:       return TVAL_W'($urandom_range(1 << LINEAR_FRAC_BITS));
            4:       return TVAL_W'($urandom);
            default: return TVAL_W'($urandom_range(4095));
        endcase
    endfunction

    function automatic logic [15:0] pick_sample();
        return 16'(sb.dec_list[$urandom_range(sb.dec_list.size() - 1)]);
    endfunction

    task automatic random_item();
        int pick;
        pick = $urandom_range(99);
        if (pick < 55) begin
            send_pixel(pick_sample(), pick_sample(), pick_sample());
        end else if (pick < 75) begin
            send_item(ACT_DEC_WR, rnd16(), rnd16(), rnd16(),
                      TIDX_W'($urandom_range(DEC_DEPTH - 1)), rand_linear());
        end else if (pick < 78) begin
            send_item(ACT_DEC_WR, rnd16(), rnd16(), rnd16(),
                      TIDX_W'($urandom_range(DEC_DEPTH, 2 ** TIDX_W - 1)), rnd_val());
        end else if (pick < 95) begin
            send_item(ACT_ENC_WR, rnd16(), rnd16(), rnd16(),
                      TIDX_W'($urandom_range(ENC_DEPTH - 1)), rnd_val());
        end else begin
            send_item(ACT_UNUSED, rnd16(), rnd16(), rnd16(), rnd_idx(), rnd_val());
        end
    endtask

    initial begin
        logic [1:0] phase_msel [N_PHASES];
        int start_count;
        bit paused;
        phase_msel = '{MSEL_IDENTITY, MSEL_FILM, MSEL_UNUSED, MSEL_DC28,
                       MSEL_FILM, MSEL_IDENTITY, MSEL_DC28, MSEL_UNUSED};
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= '0;
        i_in_valid    <= 1'b0;
        i_action      <= ACT_CONVERT;
        i_red         <= '0;
        i_green       <= '0;
        i_blue        <= '0;
        i_table_index <= '0;
        i_table_value <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: table extremes, dropped writes, unused action, saturation
        send_item(ACT_DEC_WR, rnd16(), rnd16(), rnd16(), '0, '0);
        send_item(ACT_DEC_WR, rnd16(), rnd16(), rnd16(), TIDX_W'(DEC_DEPTH - 1), '1);
        send_item(ACT_DEC_WR, rnd16(), rnd16(), rnd16(), TIDX_W'(1),
                  TVAL_W'(1) << LINEAR_FRAC_BITS);
        send_item(ACT_DEC_WR, rnd16(), rnd16(), rnd16(), TIDX_W'(2),
                  TVAL_W'(1) << (LINEAR_FRAC_BITS - 1));
        // Out of range: would alias entries 0 and the top entry if not dropped
        send_item(ACT_DEC_WR, rnd16(), rnd16(), rnd16(), TIDX_W'(DEC_DEPTH), 25'h1555555);
        send_item(ACT_DEC_WR, rnd16(), rnd16(), rnd16(), '1, '0);
        // Encode data wider than a code keeps its low bits
        send_item(ACT_ENC_WR, rnd16(), rnd16(), rnd16(), '0, '1);
        send_item(ACT_ENC_WR, rnd16(), rnd16(), rnd16(), TIDX_W'(ENC_DEPTH - 1), 25'h0ABCD);
        send_item(ACT_UNUSED, rnd16(), rnd16(), rnd16(), rnd_idx(), rnd_val());
        send_pixel(16'd0, 16'd0, 16'd0);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(16'd1, 16'd1, 16'd1);
        send_pixel(16'd1, 16'd2, 16'd0);
        send_pixel(16'd2, 16'hFFFF, 16'd1);
        send_pixel(16'd0, 16'd1, 16'hFFFF);

        for (int p = 0; p < N_PHASES; p++) begin
            drain_results();
            write_matrix(phase_msel[p]);
            case (p % 4)
                0:       begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin sender_idle_pct = 63; recv_stall_pct = 0;  end
                2:       begin sender_idle_pct = 0;  recv_stall_pct = 63; end
                default: begin sender_idle_pct = 6;  recv_stall_pct = 6;  end
            endcase
            start_count = sent_items;
            paused = 1'b0;
            while (sent_items - start_count < PHASE_ITEMS) begin
                random_item();
                // Hold off mid-phase until the pipeline is empty
                if (!paused && sent_items - start_count >= PHASE_ITEMS / 2) begin
                    drain_results();
                    paused = 1'b1;
                end
            end
        end

        i_in_valid <= 1'b0;
        while (sb.pending_codes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run summary: %0d input transfers, %0d pixel results checked, %0d mismatches",
                 sent_items, sb.checked, sb.errors);
        $display("Covered all four matrix codes, dropped and unused items, idle and stall mixes");
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/gxyz_pkg.sv
design/gxyz_matrix.sv
design/gamma_rgb_to_xyz_converter_core.sv
tb/testbench.sv
